### rtl/core/ael_pkg.sv
`timescale 1ns / 1ps

package ael_pkg;

    // Default width of the character offset counter.
    localparam int POSITION_BITS_DEFAULT = 16;

    // Fixed width of the start and length fields on the result channel.
    localparam int OUT_BITS = 16;
    localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

    // Characters the lexer recognizes.
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SLASH  = 8'h2F;

    // Token kinds as they appear on the result channel.
    typedef enum logic [2:0] {
        KIND_NUMBER = 3'd0,
        KIND_STAR   = 3'd1,
        KIND_LPAREN = 3'd2,
        KIND_MINUS  = 3'd3,
        KIND_PLUS   = 3'd4,
        KIND_RPAREN = 3'd5,
        KIND_SLASH  = 3'd6,
        KIND_ERROR  = 3'd7
    } kind_t;

    // Error codes carried with an error token.
    typedef enum logic [2:0] {
        ERR_NONE          = 3'd0,
        ERR_UNRECOGNIZED  = 3'd1,
        ERR_LEADING_ZERO  = 3'd2,
        ERR_END_AT_POINT  = 3'd3,
        ERR_AFTER_POINT   = 3'd4
    } err_t;

    // One result word.
    typedef struct packed {
        kind_t               kind;
        err_t                err;
        logic [OUT_BITS-1:0] start;
        logic [OUT_BITS-1:0] length;
        logic                last;
    } result_t;

endpackage

### rtl/core/ael_in_if.sv
`timescale 1ns / 1ps

// Character channel: one byte or an end marker per word.
interface ael_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       end_marker;

    modport source (output valid, output character, output end_marker, input ready);
    modport sink (input valid, input character, input end_marker, output ready);
endinterface

### rtl/core/ael_out_if.sv
`timescale 1ns / 1ps

// Token channel: one token or error per word.
interface ael_out_if
    import ael_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [2:0]          token_kind;
    logic [2:0]          error_code;
    logic [OUT_BITS-1:0] token_start;
    logic [OUT_BITS-1:0] token_length;
    logic                last_of_run;

    modport source (
        output valid, output token_kind, output error_code, output token_start,
        output token_length, output last_of_run, input ready
    );
    modport sink (
        input valid, input token_kind, input error_code, input token_start,
        input token_length, input last_of_run, output ready
    );
endinterface

### rtl/core/arithmetic_expression_lexer.sv
`timescale 1ns / 1ps

// Arithmetic expression lexer. Each input word carries one byte, or an end
// marker that closes the string, flushes a pending number and resets the
// offset to zero. Result words give the token kind (the operators * ( - + ) /
// or a number), its start offset and length, or an error code; after an error
// bytes are dropped until the end marker. The block accepts one byte per cycle
// while the result queue has room. A byte is registered on acceptance and is
// lexed once its results fit in a two-entry result queue that drives the
// output from a register. A byte that closes a number gives two results and is
// lexed only once the result queue is empty, so under a steady flow of results
// it can hold the input. Offsets saturate at 2^POSITION_BITS-1 and the output
// fields saturate at 65535.
module arithmetic_expression_lexer
    import ael_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    ael_in_if.sink    in_ch,
    ael_out_if.source out_ch
);

    localparam int WIDE_BITS = (POSITION_BITS > OUT_BITS) ? POSITION_BITS : OUT_BITS;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ZERO  = 3'd1,
        PH_INT   = 3'd2,
        PH_POINT = 3'd3,
        PH_FRAC  = 3'd4,
        PH_ERROR = 3'd5
    } phase_t;

    // Clamp a value to the width of the output fields.
    function automatic logic [OUT_BITS-1:0] cap_out(input logic [WIDE_BITS-1:0] v);
        logic [OUT_BITS-1:0] r;
        if (v > WIDE_BITS'(OUT_MAX))
        begin
            r = OUT_MAX;
        end
        else
        begin
            r = v[OUT_BITS-1:0];
        end
        return r;
    endfunction

    logic                     in_valid_reg;
    logic [7:0]               char_reg;
    logic                     end_reg;
    phase_t                   phase_reg;
    phase_t                   phase_next;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic [POSITION_BITS-1:0] nstart_reg;
    logic [POSITION_BITS-1:0] nstart_next;

    logic                     fire;
    logic [1:0]               space;
    logic [1:0]               n;
    result_t                  res [2];
    result_t                  head;
    logic                     q_valid;

    logic                     is_digit;
    logic                     is_zero;
    logic                     is_point;
    logic                     is_op;
    kind_t                    op_kind;
    logic [POSITION_BITS-1:0] span;
    logic [POSITION_BITS:0]   span_inc;
    logic [POSITION_BITS-1:0] span_plus;
    result_t                  num_res;
    result_t                  st_res;
    phase_t                   st_phase;
    logic                     st_number;

    // A registered byte is lexed once its results fit in the queue.
    assign fire        = in_valid_reg && (n <= space);
    assign in_ch.ready = !in_valid_reg || fire;

    // Character classes.
    assign is_zero  = (char_reg == CH_ZERO);
    assign is_digit = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
    assign is_point = (char_reg == CH_POINT);

    // Operator decoder.
    always_comb
    begin
        is_op   = 1'b1;
        op_kind = KIND_ERROR;
        unique case (char_reg)
            CH_STAR:   op_kind = KIND_STAR;
            CH_LPAREN: op_kind = KIND_LPAREN;
            CH_MINUS:  op_kind = KIND_MINUS;
            CH_PLUS:   op_kind = KIND_PLUS;
            CH_RPAREN: op_kind = KIND_RPAREN;
            CH_SLASH:  op_kind = KIND_SLASH;
            default:   is_op = 1'b0;
        endcase
    end

    // Length of the pending number, with and without the current byte.
    assign span      = pos_reg - nstart_reg;
    assign span_inc  = {1'b0, span} + {{POSITION_BITS{1'b0}}, 1'b1};
    assign span_plus = span_inc[POSITION_BITS] ? POS_MAX : span_inc[POSITION_BITS-1:0];

    // Number closed by this byte or by the end marker.
    always_comb
    begin
        num_res.kind   = KIND_NUMBER;
        num_res.err    = ERR_NONE;
        num_res.start  = cap_out(WIDE_BITS'(nstart_reg));
        num_res.length = cap_out(WIDE_BITS'(span));
        num_res.last   = 1'b0;
    end

    // The byte lexed as the first byte of a new token.
    always_comb
    begin
        st_res.kind   = is_op ? op_kind : KIND_ERROR;
        st_res.err    = is_op ? ERR_NONE : ERR_UNRECOGNIZED;
        st_res.start  = cap_out(WIDE_BITS'(pos_reg));
        st_res.length = OUT_BITS'(1);
        st_res.last   = 1'b0;
        st_number     = is_digit;
        if (is_zero)
        begin
            st_phase = PH_ZERO;
        end
        else if (is_digit)
        begin
            st_phase = PH_INT;
        end
        else if (is_op)
        begin
            st_phase = PH_IDLE;
        end
        else
        begin
            st_phase = PH_ERROR;
        end
    end

    // Lexer step for the registered byte.
    always_comb
    begin
        n           = 2'd0;
        res[0]      = num_res;
        res[1]      = st_res;
        phase_next  = phase_reg;
        nstart_next = nstart_reg;
        pos_next    = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POSITION_BITS'(1);

        if (end_reg)
        begin
            if (phase_reg == PH_ZERO || phase_reg == PH_INT || phase_reg == PH_FRAC)
            begin
                n = 2'd1;
            end
            else if (phase_reg == PH_POINT)
            begin
                n          = 2'd1;
                res[0].kind = KIND_ERROR;
                res[0].err  = ERR_END_AT_POINT;
            end
            phase_next  = PH_IDLE;
            pos_next    = '0;
            nstart_next = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    res[0]     = st_res;
                    n          = st_number ? 2'd0 : 2'd1;
                    phase_next = st_phase;
                    if (st_number)
                    begin
                        nstart_next = pos_reg;
                    end
                end
                PH_ZERO, PH_INT, PH_FRAC:
                begin
                    if (is_digit && phase_reg == PH_ZERO)
                    begin
                        n              = 2'd1;
                        res[0].kind    = KIND_ERROR;
                        res[0].err     = ERR_LEADING_ZERO;
                        res[0].length  = cap_out(WIDE_BITS'(span_plus));
                        phase_next     = PH_ERROR;
                    end
                    else if (is_digit)
                    begin
                        n = 2'd0;
                    end
                    else if (is_point && phase_reg != PH_FRAC)
                    begin
                        phase_next = PH_POINT;
                    end
                    else
                    begin
                        // The byte ends the number and starts the next token.
                        n          = st_number ? 2'd1 : 2'd2;
                        phase_next = st_phase;
                        if (st_number)
                        begin
                            nstart_next = pos_reg;
                        end
                    end
                end
                PH_POINT:
                begin
                    if (is_digit)
                    begin
                        phase_next = PH_FRAC;
                    end
                    else
                    begin
                        n             = 2'd1;
                        res[0].kind   = KIND_ERROR;
                        res[0].err    = ERR_AFTER_POINT;
                        res[0].length = cap_out(WIDE_BITS'(span_plus));
                        phase_next    = PH_ERROR;
                    end
                end
                default:
                begin
                    phase_next = PH_ERROR;
                end
            endcase
        end

        // Mark the final result of this byte.
        if (n == 2'd1)
        begin
            res[0].last = 1'b1;
        end
        else if (n == 2'd2)
        begin
            res[1].last = 1'b1;
        end
    end

    // Input register and lexer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_IDLE;
            pos_reg      <= '0;
            nstart_reg   <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                phase_reg  <= phase_next;
                pos_reg    <= pos_next;
                nstart_reg <= nstart_next;
            end
        end
    end

    // Input payload register.
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            char_reg <= in_ch.character;
            end_reg  <= in_ch.end_marker;
        end
    end

    ael_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (fire ? n : 2'd0),
        .push_data  (res),
        .space      (space),
        .out_valid  (q_valid),
        .out_ready  (out_ch.ready),
        .out_data   (head)
    );

    // Result channel.
    assign out_ch.valid        = q_valid;
    assign out_ch.token_kind   = head.kind;
    assign out_ch.error_code   = head.err;
    assign out_ch.token_start  = head.start;
    assign out_ch.token_length = head.length;
    assign out_ch.last_of_run  = head.last;

    a_error_silent: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !end_reg && phase_reg == PH_ERROR |-> n == 2'd0)
        else $error("byte in error phase produced a token");

    a_start_order: assert property (@(posedge clk) disable iff (!rst_n)
        nstart_reg <= pos_reg)
        else $error("number start beyond current offset");

    a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
        fire && end_reg |=> pos_reg == '0 && phase_reg == PH_IDLE)
        else $error("end marker did not restart the lexer");

endmodule

### rtl/core/ael_out_queue.sv
`timescale 1ns / 1ps

// Two-entry result queue. It takes up to two words per cycle and
// presents the oldest word from a register.
module ael_out_queue
    import ael_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [1:0]    push_count,
    input  result_t       push_data [2],
    output logic [1:0]    space,
    output logic          out_valid,
    input  logic          out_ready,
    output result_t       out_data
);

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    result_t    q_reg [2];
    result_t    q_next [2];
    logic       pop;
    logic [1:0] remain;
    result_t    rem0;

    // Free slots are counted before any pop so that the input side does not
    // depend on the consumer in the same cycle.
    assign space     = 2'd2 - cnt_reg;
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = q_reg[0];
    assign pop       = out_valid && out_ready;

    // Entries left after the pop, then the new words behind them.
    always_comb
    begin
        remain   = cnt_reg - {1'b0, pop};
        rem0     = pop ? q_reg[1] : q_reg[0];
        q_next   = q_reg;
        cnt_next = remain + push_count;
        if (remain == 2'd0)
        begin
            q_next[0] = push_data[0];
            q_next[1] = push_data[1];
        end
        else if (remain == 2'd1)
        begin
            q_next[0] = rem0;
            q_next[1] = push_data[0];
        end
    end

    // Occupancy count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_count <= space)
        else $error("result queue written beyond its free slots");

endmodule
